FILE: rtl/tsnps_pkg.sv
// types, constants and helpers for the ts null packet suppressor
// no dependencies; imported by every module of the block

package tsnps_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W = 16;
	localparam int MARK_W = 7;
	localparam int CNT_W = 3;
	localparam int ST_W = 2;
	localparam int BIP_W = 8;

	localparam int MAX_PACKETS = 7;

	localparam logic [BIP_W-1:0] SHORT_PKT = 8'd188;
	localparam logic [BIP_W-1:0] LONG_PKT = 8'd204;
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h47;
	localparam logic [LEN_W-1:0] NULL_PID_WORD = 16'h1FFF;

	localparam logic [LEN_W-1:0] SHORT_MAX_LEN = LEN_W'(MAX_PACKETS * 188);
	localparam logic [LEN_W-1:0] LONG_MAX_LEN = LEN_W'(MAX_PACKETS * 204);

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_LEN = 2'd1;
	localparam logic [ST_W-1:0] ST_TOO_MANY = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD_SYNC = 2'd3;

	// divisibility by the odd factors 47 and 51 of 188 and 204 via modular inverse
	localparam int Q_W = LEN_W - 2;

	function automatic logic [Q_W-1:0] odd_inverse(input logic [Q_W-1:0] d);
		logic [Q_W-1:0] x;
		x = d;
		for (int k = 0; k < 4; k++) begin
			x = Q_W'(x * Q_W'(Q_W'(2) - Q_W'(d * x)));
		end
		return x;
	endfunction

	localparam logic [Q_W-1:0] INV_47 = odd_inverse(Q_W'(47));
	localparam logic [Q_W-1:0] INV_51 = odd_inverse(Q_W'(51));
	localparam logic [Q_W-1:0] LIM_47 = Q_W'(((1 << Q_W) - 1) / 47);
	localparam logic [Q_W-1:0] LIM_51 = Q_W'(((1 << Q_W) - 1) / 51);

	localparam int RES_SLOTS = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic out_byte_valid;
		logic summary_valid;
		logic [ST_W-1:0] status;
		logic [BYTE_W-1:0] null_marks;
		logic npd_enable;
		logic [CNT_W-1:0] removed_count;
		logic [LEN_W-1:0] out_length;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t [RES_SLOTS-1:0] res;
	} push_t;

endpackage

FILE: rtl/tsnps_core.sv
// per-byte state machine of the null packet suppressor: length checks, null
// detection, two-byte hold line and result building; uses tsnps_pkg

module tsnps_core (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [tsnps_pkg::BYTE_W-1:0] data_byte,
	input logic first_byte,
	input logic [tsnps_pkg::LEN_W-1:0] payload_length,
	output tsnps_pkg::push_t push
);
	import tsnps_pkg::*;

	logic long_q;
	logic [LEN_W-1:0] bytes_left_q;
	logic [BIP_W-1:0] bip_q;
	logic [CNT_W-1:0] pkt_idx_q;
	logic [MARK_W-1:0] marks_q;
	logic [CNT_W-1:0] removed_q;
	logic [BYTE_W-1:0] held0_q, held1_q;
	logic [1:0] held_cnt_q;
	logic [ST_W-1:0] err_q;
	logic is_null_q;
	logic [LEN_W-1:0] len_kept_q;

	logic p_long, n_long;
	logic [LEN_W-1:0] p_bl, n_bl;
	logic [BIP_W-1:0] p_bip, n_bip;
	logic [CNT_W-1:0] p_pi, n_pi;
	logic [MARK_W-1:0] p_mark, n_mark;
	logic [CNT_W-1:0] p_rem, n_rem;
	logic [BYTE_W-1:0] n_h0, n_h1;
	logic [1:0] p_hc, n_hc;
	logic [ST_W-1:0] p_err, n_err;
	logic p_cin, n_cin;
	logic [LEN_W-1:0] p_lk, n_lk;

	logic [Q_W-1:0] m47, m51;
	logic div188, div204;
	logic [BIP_W-1:0] pkt_size;
	logic [BIP_W-1:0] bip_inc;
	logic active, last, zero_len;
	logic emit_a, emit_1, emit_2;
	logic [BYTE_W-1:0] c1_byte, c2_byte;
	logic [1:0] n_res;
	result_t [RES_SLOTS-1:0] res;

	assign m47 = Q_W'(payload_length[LEN_W-1:2] * INV_47);
	assign m51 = Q_W'(payload_length[LEN_W-1:2] * INV_51);
	assign div188 = (payload_length[1:0] == 2'd0) && (m47 <= LIM_47);
	assign div204 = (payload_length[1:0] == 2'd0) && (m51 <= LIM_51);

	always_comb begin
		if (first_byte) begin
			p_long = 1'b0;
			p_err = ST_OK;
			if (payload_length == '0) begin
				p_err = ST_BAD_LEN;
			end else if (div188) begin
				p_long = 1'b0;
			end else if (div204) begin
				p_long = 1'b1;
			end else begin
				p_err = ST_BAD_LEN;
			end
			if (p_err == ST_OK) begin
				if (p_long ? (payload_length > LONG_MAX_LEN) : (payload_length > SHORT_MAX_LEN)) begin
					p_err = ST_TOO_MANY;
				end else if (data_byte != SYNC_BYTE) begin
					p_err = ST_BAD_SYNC;
				end
			end
			p_bl = payload_length;
			p_bip = '0;
			p_pi = '0;
			p_mark = '0;
			p_rem = '0;
			p_hc = 2'd0;
			p_cin = 1'b0;
			p_lk = payload_length;
		end else begin
			p_long = long_q;
			p_err = err_q;
			p_bl = bytes_left_q;
			p_bip = bip_q;
			p_pi = pkt_idx_q;
			p_mark = marks_q;
			p_rem = removed_q;
			p_hc = held_cnt_q;
			p_cin = is_null_q;
			p_lk = len_kept_q;
		end

		n_long = p_long;
		n_err = p_err;
		n_bl = p_bl;
		n_bip = p_bip;
		n_pi = p_pi;
		n_mark = p_mark;
		n_rem = p_rem;
		n_h0 = held0_q;
		n_h1 = held1_q;
		n_hc = p_hc;
		n_cin = p_cin;
		n_lk = p_lk;

		pkt_size = p_long ? LONG_PKT : SHORT_PKT;
		bip_inc = p_bip + 8'd1;
		active = (p_bl != '0);
		zero_len = first_byte && (payload_length == '0);
		emit_a = 1'b0;
		last = zero_len;

		if (active) begin
			if ((p_err == ST_OK) && (p_bip == 8'd2)) begin
				n_cin = ({held1_q, data_byte} == NULL_PID_WORD);
				if (n_cin) begin
					if (p_pi < CNT_W'(MARK_W)) begin
						n_mark = p_mark | MARK_W'(7'b1 << (3'd6 - p_pi));
					end
					n_rem = p_rem + 3'd1;
					n_lk = p_lk - LEN_W'(pkt_size);
				end
			end
			case (p_hc)
				2'd0: begin
					n_h0 = data_byte;
					n_hc = 2'd1;
				end
				2'd1: begin
					n_h1 = data_byte;
					n_hc = 2'd2;
				end
				default: begin
					emit_a = !n_cin;
					n_h0 = held1_q;
					n_h1 = data_byte;
					n_hc = 2'd2;
				end
			endcase
			if (bip_inc >= pkt_size) begin
				n_bip = '0;
				n_pi = p_pi + 3'd1;
			end else begin
				n_bip = bip_inc;
			end
			n_bl = p_bl - 16'd1;
			last = (n_bl == '0);
		end

		emit_1 = active && last && !n_cin && (n_hc != 2'd0);
		emit_2 = active && last && !n_cin && (n_hc == 2'd2);
		c1_byte = n_h0;
		c2_byte = n_h1;
		if (last) begin
			n_hc = 2'd0;
		end

		res = '0;
		if (emit_a) begin
			res[0].out_byte = held0_q;
			res[0].out_byte_valid = 1'b1;
			res[1].out_byte = emit_1 ? c1_byte : '0;
			res[1].out_byte_valid = emit_1;
			res[2].out_byte = emit_2 ? c2_byte : '0;
			res[2].out_byte_valid = emit_2;
		end else begin
			res[0].out_byte = emit_1 ? c1_byte : '0;
			res[0].out_byte_valid = emit_1;
			res[1].out_byte = emit_2 ? c2_byte : '0;
			res[1].out_byte_valid = emit_2;
		end
		n_res = 2'(emit_a) + 2'(emit_1) + 2'(emit_2);
		if (last && (n_res == 2'd0)) begin
			n_res = 2'd1;
		end
		if (last) begin
			for (int k = 0; k < RES_SLOTS; k++) begin
				if (2'(k + 1) == n_res) begin
					res[k].summary_valid = 1'b1;
					res[k].status = n_err;
					res[k].null_marks = {n_long, n_mark};
					res[k].npd_enable = (n_err == ST_OK);
					res[k].removed_count = n_rem;
					res[k].out_length = n_lk;
				end
			end
		end
	end

	assign push.n = fire ? n_res : 2'd0;
	assign push.res = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= 1'b0;
			bytes_left_q <= '0;
			bip_q <= '0;
			pkt_idx_q <= '0;
			marks_q <= '0;
			removed_q <= '0;
			held_cnt_q <= 2'd0;
			err_q <= ST_OK;
			is_null_q <= 1'b0;
			len_kept_q <= '0;
		end else if (fire) begin
			long_q <= n_long;
			bytes_left_q <= n_bl;
			bip_q <= n_bip;
			pkt_idx_q <= n_pi;
			marks_q <= n_mark;
			removed_q <= n_rem;
			held_cnt_q <= n_hc;
			err_q <= n_err;
			is_null_q <= n_cin;
			len_kept_q <= n_lk;
		end
	end

	// hold line payload
	always_ff @(posedge clk) begin
		if (fire) begin
			held0_q <= n_h0;
			held1_q <= n_h1;
		end
	end

endmodule

FILE: rtl/tsnps_result_fifo.sv
// result queue: takes up to three results per transfer, hands out one per transfer
// uses tsnps_pkg

module tsnps_result_fifo (
	input logic clk,
	input logic arst_n,
	input tsnps_pkg::push_t push,
	input logic pop,
	output logic space,
	output logic not_empty,
	output tsnps_pkg::result_t head
);
	import tsnps_pkg::*;

	localparam logic [FIFO_CW-1:0] SPACE_LIM = FIFO_CW'(FIFO_DEPTH - RES_SLOTS);

	result_t slots_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] rd_ptr_q, wr_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic do_pop;

	assign not_empty = (count_q != '0);
	assign space = (count_q <= SPACE_LIM);
	assign do_pop = pop && not_empty;
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(do_pop);
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.n);
			count_q <= count_q + FIFO_CW'(push.n) - FIFO_CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < RES_SLOTS; k++) begin
			if (2'(k) < push.n) begin
				slots_q[FIFO_AW'(wr_ptr_q + FIFO_AW'(k))] <= push.res[k];
			end
		end
	end

endmodule

FILE: rtl/ts_null_packet_suppressor.sv
// top level of the mpeg ts null packet suppressor; one payload byte per transfer
// results are registered in the result queue and offered from its head in order
// throughput: one byte per cycle while in_ready is high; a payload's last byte
// yields up to three results; in_ready is low while two or more are queued
// reset: arst_n clears payload control state and empties the result queue
// depends on tsnps_pkg, tsnps_core, tsnps_result_fifo

module ts_null_packet_suppressor (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [tsnps_pkg::BYTE_W-1:0] data_byte,
	input logic first_byte,
	input logic [tsnps_pkg::LEN_W-1:0] payload_length,
	output logic out_valid,
	input logic out_ready,
	output logic [tsnps_pkg::BYTE_W-1:0] out_byte,
	output logic out_byte_valid,
	output logic summary_valid,
	output logic [tsnps_pkg::ST_W-1:0] status,
	output logic [tsnps_pkg::BYTE_W-1:0] null_marks,
	output logic npd_enable,
	output logic [tsnps_pkg::CNT_W-1:0] removed_count,
	output logic [tsnps_pkg::LEN_W-1:0] out_length
);
	import tsnps_pkg::*;

	logic in_fire;
	logic space;
	push_t push;
	result_t head;

	assign in_ready = space;
	assign in_fire = in_valid && space;

	tsnps_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(in_fire),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.payload_length(payload_length),
		.push(push)
	);

	tsnps_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(out_ready),
		.space(space),
		.not_empty(out_valid),
		.head(head)
	);

	assign out_byte = head.out_byte;
	assign out_byte_valid = head.out_byte_valid;
	assign summary_valid = head.summary_valid;
	assign status = head.status;
	assign null_marks = head.null_marks;
	assign npd_enable = head.npd_enable;
	assign removed_count = head.removed_count;
	assign out_length = head.out_length;

endmodule

FILE: rtl/tsnps_checker.sv
// port-level checks for ts_null_packet_suppressor and the bind that attaches them
// uses tsnps_pkg

module tsnps_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [tsnps_pkg::BYTE_W-1:0] out_byte,
	input logic out_byte_valid,
	input logic summary_valid,
	input logic [tsnps_pkg::ST_W-1:0] status,
	input logic [tsnps_pkg::BYTE_W-1:0] null_marks,
	input logic npd_enable,
	input logic [tsnps_pkg::CNT_W-1:0] removed_count
);
	import tsnps_pkg::*;

	// a result without a kept byte only exists to carry a summary
	a_empty_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_byte_valid |-> summary_valid && out_byte == '0)
		else $error("result with no byte and no summary");

	a_enable_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && summary_valid |-> npd_enable == (status == ST_OK))
		else $error("npd_enable disagrees with status");

	a_marks_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && summary_valid && npd_enable
		|-> $countones(null_marks[MARK_W-1:0]) == 32'(removed_count))
		else $error("null marks disagree with removed count");

	a_error_no_removal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && summary_valid && status != ST_OK
		|-> removed_count == '0 && null_marks[MARK_W-1:0] == '0)
		else $error("packets removed on an errored payload");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(summary_valid))
		else $error("result dropped before transfer");

endmodule

bind ts_null_packet_suppressor tsnps_checker u_checker (.*);
